// ----- sv/crc32bs_pkg.sv -----
// ----------------------------------------------------------------------------
// CRC-32 byte stream package
// Shared types, constants and the unrolled reflected CRC-32 byte update.
// ----------------------------------------------------------------------------
package crc32bs_pkg;

  typedef logic [31:0] crc_t;
  typedef logic [7:0]  byte_t;

  // Reflected IEEE 802.3 polynomial and the per-message seed.
  localparam crc_t CRC_POLY = 32'hEDB8_8320;
  localparam crc_t CRC_SEED = 32'hFFFF_FFFF;

  // Result handed from the datapath to the output register.
  typedef struct packed {
    logic load;
    crc_t crc;
  } result_t;

  // Folds one byte into the register, least significant bit first.
  // The eight shift/xor steps flatten into a fixed xor network.
  function automatic crc_t fold_byte(input crc_t reg_in, input byte_t data);
    crc_t r;
    r = reg_in ^ {24'h00_0000, data};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = {1'b0, r[31:1]} ^ CRC_POLY;
      end else begin
        r = {1'b0, r[31:1]};
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/crc32bs_fold.sv -----
// ----------------------------------------------------------------------------
// CRC-32 byte fold
// Selects the seed or the running value and folds one byte into it.
// ----------------------------------------------------------------------------
module crc32bs_fold (
  input  crc32bs_pkg::crc_t  crc_in,
  input  crc32bs_pkg::byte_t data,
  input  logic               reseed,
  output crc32bs_pkg::crc_t  crc_out
);
  import crc32bs_pkg::*;

  crc_t start;

  // A first byte restarts the message from all ones.
  assign start   = reseed ? CRC_SEED : crc_in;
  assign crc_out = fold_byte(start, data);

endmodule

// ----- sv/crc32bs_out_reg.sv -----
// ----------------------------------------------------------------------------
// CRC-32 result register
// Holds one finished CRC until the downstream side takes it.
// ----------------------------------------------------------------------------
module crc32bs_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  crc32bs_pkg::result_t result,
  input  logic                 crc_stall,
  output logic                 crc_valid,
  output crc32bs_pkg::crc_t    crc_value,
  output logic                 free
);
  import crc32bs_pkg::*;

  // The slot can take a new result when empty or when drained this cycle.
  assign free = !crc_valid || !crc_stall;

  // Valid flag: set on a load, cleared once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_valid <= 1'b0;
    end else if (result.load) begin
      crc_valid <= 1'b1;
    end else if (!crc_stall) begin
      crc_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (result.load) begin
      crc_value <= result.crc;
    end
  end

  // A load never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst) result.load |-> free)
    else $error("result register overwritten while stalled");

endmodule

// ----- sv/crc32_byte_stream_unit.sv -----
// ----------------------------------------------------------------------------
// CRC-32 byte stream unit
// Running reflected CRC-32 over a byte stream, result emitted uninverted.
// ----------------------------------------------------------------------------
// The unit takes one message byte per cycle unless stalled and returns the raw
// CRC register (reflected polynomial 0xEDB88320, seeded with all ones on a first
// byte, no final inversion) one item per message, after the byte marked last. A
// byte passes through an input register and is folded into the CRC register by
// an eight-step xor network; when it leaves the input register, the result of a
// last byte is loaded into the output register, from which the downstream side
// takes it. Throughput is one byte per cycle unless input stalls; the fold
// from the CRC register back into itself is the loop that sets the clock. A
// waiting result stalls input only when the byte in the input register is itself
// a last byte.
module crc32_byte_stream_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  crc32bs_pkg::byte_t  data_byte,
  input  logic                first_byte,
  input  logic                last_byte,
  output logic                crc_valid,
  input  logic                crc_stall,
  output crc32bs_pkg::crc_t   crc_value
);
  import crc32bs_pkg::*;

  logic    s1_valid;
  byte_t   s1_data;
  logic    s1_first;
  logic    s1_last;
  logic    s1_adv;
  logic    out_free;
  crc_t    crc_reg;
  crc_t    crc_next;
  result_t result;

  // The input item moves on unless it needs the output slot and the slot is busy.
  assign s1_adv     = s1_valid && (!s1_last || out_free);
  assign byte_stall = s1_valid && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_data  <= data_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  // Byte update.
  crc32bs_fold u_fold (
    .crc_in  (crc_reg),
    .data    (s1_data),
    .reseed  (s1_first),
    .crc_out (crc_next)
  );

  // Running CRC register, kept across messages.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_SEED;
    end else if (s1_adv) begin
      crc_reg <= crc_next;
    end
  end

  // A last byte hands its CRC to the result register.
  assign result.load = s1_adv && s1_last;
  assign result.crc  = crc_next;

  crc32bs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .crc_stall (crc_stall),
    .crc_valid (crc_valid),
    .crc_value (crc_value),
    .free      (out_free)
  );

  // The register comes out of reset seeded.
  assert property (@(posedge clk) (!rst && $past(rst)) |-> (crc_reg == CRC_SEED))
    else $error("CRC register not seeded after reset");

  // A new result only follows a last byte that left the input register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(crc_valid) |-> $past(s1_valid && s1_last))
    else $error("result raised without a last byte");

  // A byte that ends no message never holds up the input.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_last) |-> !byte_stall)
    else $error("non-last byte stalled");

  // The CRC register changes only when a byte is folded in.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(s1_adv)) |-> $stable(crc_reg))
    else $error("CRC register changed without a byte");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-32 byte stream unit testbench
// Drives byte messages through the unit under random input gaps and output
// stalls, predicts each uninverted CRC result and checks it in order.
// ----------------------------------------------------------------------------
module testbench;

  import crc32bs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_WAIT    = 17;
  localparam int DRAIN_WAIT  = 10;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  byte_valid = 1'b0;
  logic  byte_stall;
  byte_t data_byte  = '0;
  logic  first_byte = 1'b0;
  logic  last_byte  = 1'b0;
  logic  crc_valid;
  logic  crc_stall  = 1'b0;
  crc_t  crc_value;

  // Predictor state and the results it still owes.
  crc_t crc_running = CRC_SEED;
  crc_t crc_expected_q[$];
  crc_t crc_wanted;

  // Idling controls for each side.
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int out_hold    = 0;

  int errors        = 0;
  int bytes_sent    = 0;
  int messages_sent = 0;
  int results_seen  = 0;
  int cycles        = 0;

  crc32_byte_stream_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .crc_valid  (crc_valid),
    .crc_stall  (crc_stall),
    .crc_value  (crc_value)
  );

  // Clock: 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle counter and run timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               crc_expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Bitwise reflected CRC update: each data bit enters at the low end.
  function automatic crc_t crc_after_byte(input crc_t crc_in, input byte_t octet);
    crc_t acc;
    bit   lsb;
    acc = crc_in;
    for (int i = 0; i < 8; i++) begin
      lsb = acc[0] ^ octet[i];
      acc = acc >> 1;
      if (lsb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Sends one byte after a random gap and updates the prediction on acceptance.
  // The valid line is left high so that a following item can go out back to back.
  task automatic send_byte(input byte_t d, input bit f, input bit l);
    int gap;
    gap = in_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= d;
    first_byte <= f;
    last_byte  <= l;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (f) begin
      crc_running = CRC_SEED;
    end
    crc_running = crc_after_byte(crc_running, d);
    if (l) begin
      crc_expected_q.push_back(crc_running);
    end
    bytes_sent++;
  endtask

  // Sends a well-formed message of random bytes.
  task automatic send_message(input int len, input bit mark_first);
    for (int i = 0; i < len; i++) begin
      send_byte(byte_t'($urandom_range(0, 255)), mark_first && (i == 0), i == len - 1);
    end
    messages_sent++;
  endtask

  // Result side: random stall per item and in-order comparison.
  always @(posedge clk) begin
    if (rst) begin
      crc_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (crc_valid && !crc_stall) begin
        results_seen++;
        if (crc_expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result crc_value=%08h", $time, crc_value);
        end else begin
          crc_wanted = crc_expected_q.pop_front();
          if (crc_value !== crc_wanted) begin
            errors++;
            $display("%0t: crc_value mismatch expected=%08h actual=%08h", $time,
                     crc_wanted, crc_value);
          end
        end
        out_hold = out_idle_en ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (out_hold > 0) begin
        crc_stall <= 1'b1;
        out_hold--;
      end else begin
        crc_stall <= 1'b0;
      end
    end
  end

  // Extremes, single-byte messages, the check string, missing and repeated
  // first marks, and a stream that starts without a first mark after reset.
  task automatic test_directed();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    for (int i = 1; i <= 9; i++) begin
      send_byte(byte_t'(8'h30 + i), i == 1, i == 9);
    end
    // The register carries over when the next message lacks its first mark.
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    // A first mark in the middle of a message reseeds the register again.
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    messages_sent += 7;
  endtask

  // Well-formed messages, mostly short, a few long, some without a first mark.
  task automatic test_random_messages(input int n_items);
    int start;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      send_message(len, $urandom_range(0, 9) != 0);
    end
  endtask

  // Independent random marks: broken and overlapping messages.
  task automatic test_noise(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
    end
  endtask

  // Input runs flat out while the result side stalls: backpressure on input.
  task automatic test_backpressure(input int n_items);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    test_random_messages(n_items);
    in_idle_en  = 1'b1;
  endtask

  // No idling on either side.
  task automatic test_back_to_back(input int n_items);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_messages(n_items);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_messages(800);
    test_backpressure(400);
    test_noise(200);
    test_back_to_back(150);

    byte_valid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes in about %0d messages, checked %0d CRC results.",
             bytes_sent, messages_sent, results_seen);
    $display("Covered random gaps, output stalls, broken marks and back-to-back traffic.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/crc32bs_pkg.sv
sv/crc32bs_fold.sv
sv/crc32bs_out_reg.sv
sv/crc32_byte_stream_unit.sv
tb/sv/testbench.sv
